### design/ordered_key_value_table_macros.svh
// assertion macros for the checker file of the key/value table
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

// clocked on clk_i, quiet while rst_ni is low
`define OKVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked on clk_i, also checked during reset
`define OKVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/okvt_pkg.sv
// shared constants, codes and types of the ordered key/value table
package okvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;

  // fixed field widths of the channels
  localparam int CMD_FIELD_W    = 3;
  localparam int KEY_FIELD_W    = 32;
  localparam int VAL_FIELD_W    = 32;
  localparam int RVAL_FIELD_W   = 32;
  localparam int STATUS_FIELD_W = 2;
  localparam int COUNT_FIELD_W  = 5;

  typedef enum logic [CMD_FIELD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REM_KEY = 3'd1,
    CMD_REM_VAL = 3'd2,
    CMD_LOOKUP  = 3'd3,
    CMD_RD_ERR  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_FIELD_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

endpackage

### design/okvt_if.sv
// request and response channel interfaces of the ordered key/value table
interface okvt_req_if;
  import okvt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_FIELD_W-1:0] command;
  logic [KEY_FIELD_W-1:0] key;
  logic [VAL_FIELD_W-1:0] entry_value;

  modport source (output valid, output command, output key, output entry_value,
                  input ready);
  modport sink   (input valid, input command, input key, input entry_value,
                  output ready);
endinterface

interface okvt_rsp_if;
  import okvt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [RVAL_FIELD_W-1:0]   read_value;
  logic [STATUS_FIELD_W-1:0] status;
  logic                      error_code;
  logic [COUNT_FIELD_W-1:0]  entry_count;

  modport source (output valid, output read_value, output status, output error_code,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input status, input error_code,
                  input entry_count, output ready);
endinterface

### design/okvt_ram.sv
// generic single-write, single-read ram with registered read data
module okvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/ordered_key_value_table.sv
// top level of the ordered key/value table
// Ordered key/value table: up to TABLE_DEPTH pairs held in insertion order in one
// synchronous ram (key and value side by side), searched linearly. One request is
// worked at a time and gives exactly one response. Add, read-error and unused
// commands go from acceptance straight to the result state. Remove-by-key,
// remove-by-value and lookup walk the entries through the single read port of
// the ram, one entry per cycle, over the entries held at acceptance (lookup
// stops at the first matching key). Removes read entry i and write the
// survivors back at a trailing write pointer in the same pass, closing the gaps.
// A finished response sits in an output register, so the next request is taken
// while it waits; a new response is only loaded once that register is free. The
// ram needs no clearing: only entries below the count are used.
module ordered_key_value_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  okvt_req_if.sink    req_i,
  okvt_rsp_if.source  rsp_o
);
  import okvt_pkg::*;

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 last_err_q, last_err_d;
  logic                 out_valid_q, out_valid_d;

  // request captured for the scan
  cmd_e                 cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [IDX_W-1:0]     rd_q, rd_d;      // entry whose data the ram returns now
  logic [CNT_W-1:0]     wr_q, wr_d;      // next slot for a surviving entry

  // pending response
  logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  status_e              res_status_q, res_status_d;
  logic                 res_err_q, res_err_d;

  // output register
  logic [RVAL_FIELD_W-1:0]   out_value_q, out_value_d;
  logic [STATUS_FIELD_W-1:0] out_status_q, out_status_d;
  logic                      out_err_q, out_err_d;
  logic [COUNT_FIELD_W-1:0]  out_count_q, out_count_d;

  // ram port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic                   req_acc;
  logic                   out_free;
  logic                   scan_done;
  logic                   last_entry;
  logic                   hit_key;
  logic                   hit_val;
  logic                   drop;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  cmd_e                   req_cmd;

  okvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one request at a time; the output register decouples the response side
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // input bits above the stored widths are ignored
  assign key_in  = KEY_WIDTH'(req_i.key);
  assign val_in  = VALUE_WIDTH'(req_i.entry_value);
  assign req_cmd = cmd_e'(req_i.command);

  assign rd_key     = ram_rdata[ENTRY_W-1:VALUE_WIDTH];
  assign rd_val     = ram_rdata[VALUE_WIDTH-1:0];
  assign hit_key    = (rd_key == key_q);
  assign hit_val    = (rd_val == val_q);
  assign drop       = (cmd_q == CMD_REM_KEY) ? hit_key : hit_val;
  assign last_entry = ((CNT_W'(rd_q) + CNT_W'(1)) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if ((req_cmd == CMD_REM_KEY || req_cmd == CMD_REM_VAL || req_cmd == CMD_LOOKUP)
              && (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_d      = count_q;
    last_err_d   = last_err_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_err_d    = res_err_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_err_d    = out_err_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q[IDX_W-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    scan_done    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // the first entry is read while the request is taken
        if (req_acc) begin
          cmd_d        = req_cmd;
          key_d        = key_in;
          val_d        = val_in;
          rd_d         = '0;
          wr_d         = '0;
          res_value_d  = '0;
          res_status_d = STAT_OK;
          res_err_d    = 1'b0;
          unique case (req_cmd)
            CMD_ADD: begin
              if (count_q < CNT_W'(TABLE_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IDX_W-1:0];
                ram_wdata = {key_in, val_in};
                count_d   = count_q + CNT_W'(1);
              end else begin
                res_status_d = STAT_FULL;
              end
            end
            CMD_LOOKUP: begin
              // empty table: miss without a scan
              if (count_q == '0) begin
                res_status_d = STAT_NOTFOUND;
                last_err_d   = 1'b1;
              end
            end
            CMD_RD_ERR: begin
              res_err_d  = last_err_q;
              last_err_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ram_raddr = rd_q + IDX_W'(1);
        rd_d      = rd_q + IDX_W'(1);
        if (cmd_q == CMD_LOOKUP) begin
          if (hit_key) begin
            res_value_d = rd_val;
            last_err_d  = 1'b0;
            scan_done   = 1'b1;
          end else if (last_entry) begin
            res_status_d = STAT_NOTFOUND;
            last_err_d   = 1'b1;
            scan_done    = 1'b1;
          end
        end else begin
          // survivors move down to the write pointer, which never passes the read one
          if (!drop) begin
            ram_we = 1'b1;
            wr_d   = wr_q + CNT_W'(1);
          end
          if (last_entry) begin
            count_d   = wr_q + CNT_W'(!drop);
            scan_done = 1'b1;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = RVAL_FIELD_W'(res_value_q);
          out_status_d = res_status_q;
          out_err_d    = res_err_q;
          out_count_d  = COUNT_FIELD_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      last_err_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_err_q  <= last_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    rd_q         <= rd_d;
    wr_q         <= wr_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_err_q    <= res_err_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_err_q    <= out_err_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.error_code  = out_err_q;
  assign rsp_o.entry_count = out_count_q;

endmodule

### design/okvt_checker.sv
// port-level checker of the ordered key/value table and its bind
`include "ordered_key_value_table_macros.svh"

module okvt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic [okvt_pkg::RVAL_FIELD_W-1:0]   read_value_i,
  input logic [okvt_pkg::STATUS_FIELD_W-1:0] status_i,
  input logic                                error_code_i,
  input logic [okvt_pkg::COUNT_FIELD_W-1:0]  entry_count_i
);
  import okvt_pkg::*;

  `OKVT_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped while stalled")
  `OKVT_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(read_value_i) && $stable(status_i) && $stable(error_code_i) && $stable(entry_count_i), "stalled response changed")
  `OKVT_ASSERT(a_full_count, rsp_valid_i && status_i == STAT_FULL |-> entry_count_i == COUNT_FIELD_W'(TABLE_DEPTH), "add dropped on a table that is not full")
  `OKVT_ASSERT(a_miss_zero, rsp_valid_i && status_i == STAT_NOTFOUND |-> read_value_i == '0 && !error_code_i, "lookup miss carries data")
  `OKVT_ASSERT(a_err_clean, rsp_valid_i && error_code_i |-> status_i == STAT_OK && read_value_i == '0, "error report with stray fields")

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_value_i  (rsp_o.read_value),
  .status_i      (rsp_o.status),
  .error_code_i  (rsp_o.error_code),
  .entry_count_i (rsp_o.entry_count)
);
